[rtl/core/bm25ts_pkg.sv]
`default_nettype none

package bm25ts_pkg;

	// Field widths of the beats.
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned SCORE_W = 24;

	// Configuration register map (index = paddr[4:3]).
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_TOTAL_DOCS    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TOTAL_TOKENS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_K1_GAIN       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH_WEIGHT = 2'd3;

	localparam int unsigned TOKENS_W = 40;
	localparam int unsigned K1_W     = 12;
	localparam int unsigned B_W      = 9;

	localparam logic [K1_W-1:0] K1_RESET = 12'd384;
	localparam logic [B_W-1:0]  B_RESET  = 9'd192;
	localparam logic [B_W-1:0]  B_ONE    = 9'd256;

	// Logarithm unit: argument up to 2N+2, result Q6.32.
	localparam int unsigned LOG_IN_W   = 34;
	localparam int unsigned LOG_FRAC   = 32;
	localparam int unsigned LOG_EXP_W  = 6;
	localparam int unsigned LOG_OUT_W  = LOG_EXP_W + LOG_FRAC;

	// ln(2) with 32 fraction bits.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Divider: numerator core is the numerator shifted down by 40 bits.
	localparam int unsigned NUMC_W   = 85;
	localparam int unsigned NUM_SH   = 40;
	localparam int unsigned DEN_W    = 89;
	localparam int unsigned REM_W    = NUMC_W + NUM_SH;
	localparam int unsigned QUO_W    = 37;

	localparam int unsigned IDF_W    = 39;
	localparam int unsigned PROD_W   = IDF_W + QUO_W;

	typedef struct packed {
		logic [FIELD_W-1:0] doc_freq;
		logic [FIELD_W-1:0] term_freq;
		logic [FIELD_W-1:0] doc_len;
	} bm25ts_in_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               invalid;
	} bm25ts_out_t;

	typedef struct packed {
		logic vld;
		logic bad;
	} bm25ts_ctl_t;

endpackage

`default_nettype wire

[rtl/core/bm25ts_log2.sv]
`default_nettype none

// Pipelined log2 with 32 fraction bits: two normalisation stages, then one
// squaring stage for each fraction bit.
module bm25ts_log2 import bm25ts_pkg::*; (
	input  wire logic                 clk,
	input  wire logic [LOG_IN_W-1:0]  arg,
	output logic      [LOG_OUT_W-1:0] log_val
);

	logic [LOG_EXP_W-1:0]          exp_c;
	logic [LOG_IN_W-1:0]           arg_sa;
	logic [LOG_EXP_W-1:0]          exp_sa;
	logic [LOG_IN_W+LOG_FRAC-1:0]  wide_c;

	logic [LOG_FRAC-1:0]  mant_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0]  frac_s [0:LOG_FRAC];
	logic [LOG_EXP_W-1:0] exp_s  [0:LOG_FRAC];

	always_comb begin
		exp_c = '0;
		for (int k = 0; k < LOG_IN_W; k++) begin
			if (arg[k]) begin
				exp_c = LOG_EXP_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		arg_sa <= arg;
		exp_sa <= exp_c;
	end

	// Leading one lands on bit 31 of the mantissa; lower bits are dropped.
	assign wide_c = {arg_sa, {LOG_FRAC{1'b0}}} >> exp_sa;

	always_ff @(posedge clk) begin
		mant_s[0] <= wide_c[LOG_FRAC:1];
		frac_s[0] <= '0;
		exp_s[0]  <= exp_sa;
	end

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
		logic [2*LOG_FRAC-1:0] sq;
		logic [LOG_FRAC:0]     top;

		assign sq  = (2*LOG_FRAC)'(mant_s[k]) * (2*LOG_FRAC)'(mant_s[k]);
		assign top = sq[2*LOG_FRAC-1:LOG_FRAC-1];

		always_ff @(posedge clk) begin
			mant_s[k+1] <= top[LOG_FRAC] ? top[LOG_FRAC:1] : top[LOG_FRAC-1:0];
			frac_s[k+1] <= {frac_s[k][LOG_FRAC-2:0], top[LOG_FRAC]};
			exp_s[k+1]  <= exp_s[k];
		end
	end

	assign log_val = {exp_s[LOG_FRAC], frac_s[LOG_FRAC]};

endmodule

`default_nettype wire

[rtl/core/bm25ts_div.sv]
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
module bm25ts_div import bm25ts_pkg::*; (
	input  wire logic              clk,
	input  wire logic [NUMC_W-1:0] numc,
	input  wire logic [DEN_W-1:0]  den,
	output logic      [QUO_W-1:0]  quo
);

	logic [REM_W-1:0] rem_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [REM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [REM_W-1:0] den_sh;
		logic [REM_W:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in = {numc, {NUM_SH{1'b0}}};
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign quo_in = quo_s[k];
		end

		assign den_sh = REM_W'(den_in) << (QUO_W - 1 - k);
		assign diff   = {1'b0, rem_in} - {1'b0, den_sh};

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_in;
			if (!diff[REM_W]) begin
				rem_s[k+1] <= diff[REM_W-1:0];
				quo_s[k+1] <= {quo_in[QUO_W-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= rem_in;
				quo_s[k+1] <= {quo_in[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

`default_nettype wire

[rtl/core/bm25_term_score_core.sv]
`default_nettype none

// Channel   | Ports                                      | Beat
// ----------+--------------------------------------------+------------------------------
// item      | start, busy, item                          | doc_freq, term_freq, doc_len
// result    | done, result                               | score, invalid
// config    | psel, penable, pwrite, paddr, pwdata,      | 64-bit registers at 8*index
//           | prdata, pready                             |
//
// One beat can be taken in every cycle; busy is never raised.
// Each beat gives its result in order.
// The latency is set by the 37-stage restoring divider for the tf ratio plus
// its operand products, with the two 34-stage log2 pipelines running beside it.
// arst_n clears the stage valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
module bm25_term_score_core import bm25ts_pkg::*; #(
	parameter int unsigned COUNT_WIDTH     = 32,
	parameter int unsigned SCORE_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire bm25ts_in_t  item,
	output logic             done,
	output bm25ts_out_t      result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);

	// Counts narrower than 32 bits keep only their low bits.
	localparam int unsigned CNT_W = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;
	localparam logic [FIELD_W-1:0] CNT_MASK = FIELD_W'((64'd1 << CNT_W) - 64'd1);
	localparam int unsigned LAST = 45;
	localparam int unsigned LATENCY = LAST;

	// Configuration registers.
	logic [FIELD_W-1:0]  total_docs_q;
	logic [TOKENS_W-1:0] total_tokens_q;
	logic [K1_W-1:0]     k1_gain_q;
	logic [B_W-1:0]      length_weight_q;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_docs_q    <= '0;
			total_tokens_q  <= '0;
			k1_gain_q       <= K1_RESET;
			length_weight_q <= B_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_TOTAL_DOCS:    total_docs_q    <= pwdata[FIELD_W-1:0];
				REG_TOTAL_TOKENS:  total_tokens_q  <= pwdata[TOKENS_W-1:0];
				REG_K1_GAIN:       k1_gain_q       <= pwdata[K1_W-1:0];
				REG_LENGTH_WEIGHT: length_weight_q <= pwdata[B_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOTAL_DOCS:    prdata = 64'(total_docs_q);
			REG_TOTAL_TOKENS:  prdata = 64'(total_tokens_q);
			REG_K1_GAIN:       prdata = 64'(k1_gain_q);
			REG_LENGTH_WEIGHT: prdata = 64'(length_weight_q);
			default:           prdata = '0;
		endcase
	end

	// Values of b above one act as one. The user must change k1 and b only while
	// idle, as every stage reads them directly; the block does not enforce this.
	logic [B_W-1:0]  b_c;
	logic [K1_W:0]   k1p_c;
	assign b_c   = (length_weight_q > B_ONE) ? B_ONE : length_weight_q;
	assign k1p_c = (K1_W+1)'(k1_gain_q) + (K1_W+1)'(B_ONE);

	// Stage 1: take the beat, mask the counts and check their consistency.
	logic               accept;
	logic [FIELD_W-1:0] n_c, df_c, tf_c, len_c;
	logic               bad_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign n_c    = total_docs_q & CNT_MASK;
	assign df_c   = item.doc_freq & CNT_MASK;
	assign tf_c   = item.term_freq & CNT_MASK;
	assign len_c  = item.doc_len & CNT_MASK;
	assign bad_c  = (n_c == '0) || (df_c == '0) || (df_c > n_c) || (tf_c == '0) ||
			(tf_c > len_c) || (total_tokens_q == '0);

	bm25ts_ctl_t ctl_s [1:LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				ctl_s[k] <= '0;
			end
		end else begin
			ctl_s[1] <= '{vld: accept, bad: bad_c};
			for (int k = 2; k <= LAST; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	logic [FIELD_W-1:0]  n_s1, tf_s1, len_s1;
	logic [LOG_IN_W-1:0] logn_arg_s1, logd_arg_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			n_s1        <= n_c;
			tf_s1       <= tf_c;
			len_s1      <= len_c;
			// The idf argument is (2N+2)/(2df+1).
			logn_arg_s1 <= {1'b0, n_c, 1'b0} + LOG_IN_W'(2);
			logd_arg_s1 <= {1'b0, df_c, 1'b1};
		end
	end

	// Ratio path, stage 2: the small products.
	logic [44:0]        p_tfk_s2;
	logic [63:0]        lnn_s2;
	logic [20:0]        kb_s2, kbn_s2;
	logic [FIELD_W-1:0] tf_s2;

	always_ff @(posedge clk) begin
		p_tfk_s2 <= 45'(tf_s1) * 45'(k1p_c);
		lnn_s2   <= 64'(len_s1) * 64'(n_s1);
		kb_s2    <= 21'(k1_gain_q) * 21'(b_c);
		kbn_s2   <= 21'(k1_gain_q) * 21'(B_ONE - b_c);
		tf_s2    <= tf_s1;
	end

	// Stage 3: partial products against the token total and len*N.
	logic [64:0] pn_lo_s3, pn_hi_s3;
	logic [51:0] pd1_lo_s3, pd1_hi_s3;
	logic [60:0] d2_s3;
	logic [52:0] pd3_lo_s3, pd3_hi_s3;

	always_ff @(posedge clk) begin
		pn_lo_s3  <= 65'(p_tfk_s2) * 65'(total_tokens_q[19:0]);
		pn_hi_s3  <= 65'(p_tfk_s2) * 65'(total_tokens_q[39:20]);
		pd1_lo_s3 <= 52'(tf_s2) * 52'(total_tokens_q[19:0]);
		pd1_hi_s3 <= 52'(tf_s2) * 52'(total_tokens_q[39:20]);
		d2_s3     <= 61'(kbn_s2) * 61'(total_tokens_q);
		pd3_lo_s3 <= 53'(kb_s2) * 53'(lnn_s2[31:0]);
		pd3_hi_s3 <= 53'(kb_s2) * 53'(lnn_s2[63:32]);
	end

	// Stage 4: gather the partial products.
	logic [NUMC_W-1:0] numc_s4;
	logic [71:0]       d1_s4;
	logic [60:0]       d2_s4;
	logic [84:0]       d3_s4;

	always_ff @(posedge clk) begin
		numc_s4 <= NUMC_W'(pn_lo_s3) + (NUMC_W'(pn_hi_s3) << 20);
		d1_s4   <= 72'(pd1_lo_s3) + (72'(pd1_hi_s3) << 20);
		d2_s4   <= d2_s3;
		d3_s4   <= 85'(pd3_lo_s3) + (85'(pd3_hi_s3) << 32);
	end

	// Stage 5: the denominator tf*65536*T + k1*(256-b)*T + k1*b*len*N.
	logic [NUMC_W-1:0] numc_s5;
	logic [DEN_W-1:0]  den_s5;

	always_ff @(posedge clk) begin
		numc_s5 <= numc_s4;
		den_s5  <= (DEN_W'(d1_s4) << 16) + DEN_W'(d2_s4) + DEN_W'(d3_s4);
	end

	// Stages 6 to 42: the ratio as an unsigned Q5.32.
	logic [QUO_W-1:0] ratio_s42;

	bm25ts_div u_div (
		.clk  (clk),
		.numc (numc_s5),
		.den  (den_s5),
		.quo  (ratio_s42)
	);

	// idf path, stages 2 to 35: both logarithms.
	logic [LOG_OUT_W-1:0] logn_s35, logd_s35;

	bm25ts_log2 u_log_n (
		.clk     (clk),
		.arg     (logn_arg_s1),
		.log_val (logn_s35)
	);

	bm25ts_log2 u_log_d (
		.clk     (clk),
		.arg     (logd_arg_s1),
		.log_val (logd_s35)
	);

	logic [LOG_OUT_W-1:0] diff_s36;
	logic [37:0]          iph_s37;
	logic [31:0]          ipl_s37;
	logic [IDF_W-1:0]     idf_s38;
	logic [IDF_W-1:0]     idf_s [39:42];

	always_ff @(posedge clk) begin
		diff_s36 <= logn_s35 - logd_s35;
		// Scale by ln(2): integer and fraction parts separately, the fraction truncated.
		iph_s37  <= 38'(diff_s36[LOG_OUT_W-1:LOG_FRAC]) * 38'(LN2_Q32);
		ipl_s37  <= 32'((64'(diff_s36[LOG_FRAC-1:0]) * 64'(LN2_Q32)) >> 32);
		idf_s38  <= IDF_W'(iph_s37) + IDF_W'(ipl_s37);
		// Wait for the ratio.
		idf_s[39] <= idf_s38;
		for (int k = 40; k <= 42; k++) begin
			idf_s[k] <= idf_s[k-1];
		end
	end

	// Stages 43 and 44: idf times ratio in two partial products.
	logic [57:0]       pr_lo_s43;
	logic [56:0]       pr_hi_s43;
	logic [PROD_W-1:0] prod_s44;

	always_ff @(posedge clk) begin
		pr_lo_s43 <= 58'(idf_s[42]) * 58'(ratio_s42[18:0]);
		pr_hi_s43 <= 57'(idf_s[42]) * 57'(ratio_s42[QUO_W-1:19]);
		prod_s44  <= PROD_W'(pr_lo_s43) + (PROD_W'(pr_hi_s43) << 19);
	end

	// Stage 45: drop to the score format and saturate, or flag a bad beat.
	logic [PROD_W-1:0] shifted_c;
	logic              sat_c;
	bm25ts_out_t       result_s45;

	assign shifted_c = prod_s44 >> (64 - SCORE_FRAC_BITS);
	assign sat_c     = |shifted_c[PROD_W-1:SCORE_W];

	always_ff @(posedge clk) begin
		if (ctl_s[LAST-1].bad) begin
			result_s45.score   <= '0;
			result_s45.invalid <= 1'b1;
		end else begin
			result_s45.score   <= sat_c ? {SCORE_W{1'b1}} : shifted_c[SCORE_W-1:0];
			result_s45.invalid <= 1'b0;
		end
	end

	assign done   = ctl_s[LAST].vld;
	assign result = result_s45;

`ifndef ASSERT_OFF
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("taken beat did not give a result on time");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching taken beat");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.invalid |-> result.score == '0)
		else $error("flagged result carries a non-zero score");
`endif

endmodule

`default_nettype wire

[tb/bm25_term_score_core_tb.sv]
`default_nettype none

// Testbench for the BM25 posting scorer. A short directed table sets up
// register values and postings, typing the expected beat where it is obvious
// (reset values, inconsistent operands, saturation). A random part follows,
// with several register settings in each of three idling phases. Every result
// beat is checked in order against its typed beat or a fixed-point scorer kept in this file.
module bm25_term_score_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bm25ts_pkg::*;

	localparam int unsigned PIPE_LAT    = 45;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam logic [63:0] SCORE_SAT   = 64'hFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	bm25ts_in_t  item;
	logic        done;
	bm25ts_out_t result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	bm25_term_score_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the registers, updated on the same edge as the block's.
	logic [31:0]       corpus_docs;
	logic [39:0]       corpus_tokens;
	logic [K1_W-1:0]   k1_q8;
	logic [B_W-1:0]    b_q8;

	bm25ts_out_t       pending_scores[$];
	int                errors;
	int                idle_cycles;

	// A directed row may carry its own expected beat; it travels with the item.
	logic              typed_chk;
	bm25ts_out_t       typed_val;

	// log2 with 32 fraction bits by repeated squaring of the mantissa.
	function automatic logic [63:0] log2_q32(logic [63:0] v);
		int          e;
		logic [63:0] m;
		logic [63:0] frac;
		e = 0;
		frac = '0;
		while (e < 63 && (v >> (e + 1)) != 0)
			e++;
		m = (e > 31) ? (v >> (e - 31)) : (v << (31 - e));
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(e) << 32) | frac;
	endfunction

	function automatic bm25ts_out_t bm25_score(bm25ts_in_t p);
		logic [63:0]  n, df, tf, len, t, k1, b, diff, idf, ratio;
		logic [127:0] num, den, prod;
		bm25ts_out_t  r;
		n   = 64'(corpus_docs);
		df  = 64'(p.doc_freq);
		tf  = 64'(p.term_freq);
		len = 64'(p.doc_len);
		t   = 64'(corpus_tokens);
		k1  = 64'(k1_q8);
		b   = (b_q8 > B_ONE) ? 64'(B_ONE) : 64'(b_q8);
		r.score = '0;
		r.invalid = 1'b1;
		// Inconsistent postings or an empty corpus give a flagged zero score.
		if (n == 0 || df == 0 || df > n || tf == 0 || tf > len || t == 0)
			return r;
		diff = log2_q32(2 * n + 2) - log2_q32(2 * df + 1);
		idf = (diff >> 32) * 64'(LN2_Q32) + ((64'(diff[31:0]) * 64'(LN2_Q32)) >> 32);
		num = (128'(tf * (k1 + 256) * 256) * 128'(t)) << 32;
		den = 128'(tf << 16) * 128'(t) + 128'(k1 * (256 - b)) * 128'(t)
			+ 128'(k1 * b) * 128'(len * n);
		ratio = 64'(num / den);
		prod = 128'(idf) * 128'(ratio);
		r.score = ((prod >> 48) > 128'(SCORE_SAT)) ? SCORE_SAT[SCORE_W-1:0]
			: prod[48 +: SCORE_W];
		r.invalid = 1'b0;
		return r;
	endfunction

	// Accepted beats, register writes and result checks, all at the rising edge.
	always @(posedge clk) begin
		bm25ts_out_t want;
		logic        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (start && !busy) begin
				want = typed_chk ? typed_val : bm25_score(item);
				pending_scores = {pending_scores, want};
				moved = 1'b1;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_TOTAL_DOCS:    corpus_docs <= pwdata[31:0];
					REG_TOTAL_TOKENS:  corpus_tokens <= pwdata[39:0];
					REG_K1_GAIN:       k1_q8 <= pwdata[K1_W-1:0];
					REG_LENGTH_WEIGHT: b_q8 <= pwdata[B_W-1:0];
					default: ;
				endcase
				moved = 1'b1;
			end
			if (done) begin
				moved = 1'b1;
				if (pending_scores.size() == 0) begin
					$display("%0t: result beat with nothing expected: score %h invalid %b",
						$realtime, result.score, result.invalid);
					errors++;
				end else begin
					want = pending_scores.pop_front();
					if (result.score !== want.score) begin
						$display("%0t: score expected %h actual %h",
							$realtime, want.score, result.score);
						errors++;
					end
					if (result.invalid !== want.invalid) begin
						$display("%0t: invalid expected %b actual %b",
							$realtime, want.invalid, result.invalid);
						errors++;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Offers one beat, idling the given share of cycles, and returns on the edge
	// it is taken.
	task automatic offer_posting(bm25ts_in_t p, logic chk, bm25ts_out_t val, int gap_pct);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= p;
		typed_chk <= chk;
		typed_val <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Registers may only change with the pipeline empty.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
		start <= 1'b0;
		typed_chk <= 1'b0;
		@(posedge clk);
		while (pending_scores.size() != 0)
			@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] rand_bits(int unsigned w);
		logic [63:0] v;
		int unsigned k;
		v = {$urandom, $urandom};
		k = $urandom_range(1, w);
		return (k >= 64) ? v : (v & ((64'd1 << k) - 1));
	endfunction

	typedef struct {
		logic                 is_reg;
		logic [REG_IDX_W-1:0] idx;
		logic [63:0]          val;
		bm25ts_in_t           p;
		logic                 chk;
		bm25ts_out_t          want;
	} stim_row_t;

	stim_row_t directed_rows[$];

	function automatic void add_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
		stim_row_t r;
		r = '{is_reg: 1'b1, idx: idx, val: val, p: '0, chk: 1'b0, want: '0};
		directed_rows = {directed_rows, r};
	endfunction

	function automatic void add_posting(logic [31:0] df, logic [31:0] tf, logic [31:0] len,
		logic chk, logic [SCORE_W-1:0] score, logic inv);
		stim_row_t r;
		r = '{is_reg: 1'b0, idx: '0, val: '0, p: '{df, tf, len}, chk: chk,
			want: '{score, inv}};
		directed_rows = {directed_rows, r};
	endfunction

	// Mostly well-formed postings within the current corpus, the rest raw noise.
	function automatic bm25ts_in_t random_posting();
		bm25ts_in_t  p;
		logic [31:0] lim;
		p.doc_freq  = 32'(rand_bits(32));
		p.term_freq = 32'(rand_bits(32));
		p.doc_len   = 32'(rand_bits(32));
		if (corpus_docs != 0 && $urandom_range(99) < 80) begin
			p.doc_freq = $urandom_range(1, corpus_docs);
			if (p.doc_len == 0)
				p.doc_len = 1;
			lim = ($urandom_range(1) != 0 && p.doc_len > 20) ? 32'd20 : p.doc_len;
			p.term_freq = $urandom_range(1, lim);
		end
		return p;
	endfunction

	initial begin
		int          gap_pct[3];
		logic [63:0] v;
		errors = 0;
		idle_cycles = 0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		typed_chk = 1'b0;
		typed_val = '0;
		corpus_docs = '0;
		corpus_tokens = '0;
		k1_q8 = K1_RESET;
		b_q8 = B_RESET;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// After reset the corpus is empty, so everything is flagged.
		add_posting(32'd5, 32'd10, 32'd20, 1'b1, '0, 1'b1);
		add_reg(REG_TOTAL_DOCS, 64'd1000);
		add_reg(REG_TOTAL_TOKENS, 64'd300000);
		add_posting(32'd0, 32'd3, 32'd300, 1'b1, '0, 1'b1);
		add_posting(32'd1001, 32'd3, 32'd300, 1'b1, '0, 1'b1);
		add_posting(32'd10, 32'd0, 32'd300, 1'b1, '0, 1'b1);
		add_posting(32'd10, 32'd21, 32'd20, 1'b1, '0, 1'b1);
		add_posting(32'd1, 32'd1, 32'd1, 1'b0, '0, 1'b0);
		add_posting(32'd1000, 32'd5, 32'd300, 1'b0, '0, 1'b0);
		add_posting(32'd10, 32'd3, 32'd300, 1'b0, '0, 1'b0);
		add_posting(32'd500, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
		add_posting(32'd1, 32'd1, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
		// An empty token total is inconsistent too.
		add_reg(REG_TOTAL_TOKENS, 64'd0);
		add_posting(32'd10, 32'd3, 32'd300, 1'b1, '0, 1'b1);
		// Largest corpus, largest k1 and no length weighting drive the score
		// past its range, so it saturates.
		add_reg(REG_TOTAL_DOCS, 64'hFFFF_FFFF);
		add_reg(REG_TOTAL_TOKENS, 64'hFF_FFFF_FFFF);
		add_reg(REG_K1_GAIN, 64'd4095);
		add_reg(REG_LENGTH_WEIGHT, 64'd0);
		add_posting(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, SCORE_SAT[SCORE_W-1:0], 1'b0);
		add_posting(32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0, '0, 1'b0);
		add_reg(REG_K1_GAIN, 64'd0);
		add_reg(REG_LENGTH_WEIGHT, 64'd256);
		add_posting(32'd7, 32'd2, 32'd9, 1'b0, '0, 1'b0);
		add_reg(REG_K1_GAIN, 64'd384);
		// A weight above one behaves as exactly one.
		add_reg(REG_LENGTH_WEIGHT, 64'd511);
		add_posting(32'd7, 32'd2, 32'd9, 1'b0, '0, 1'b0);
		add_posting(32'd3, 32'd40, 32'd1_000_000, 1'b0, '0, 1'b0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg)
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			else
				offer_posting(directed_rows[i].p, directed_rows[i].chk,
					directed_rows[i].want, 0);
		end

		gap_pct = '{15, 76, 0};
		for (int ph = 0; ph < 3; ph++) begin
			for (int s = 0; s < 5; s++) begin
				v = ($urandom_range(9) == 0) ? 64'd0 : rand_bits(64);
				write_reg(REG_TOTAL_DOCS, v);
				v = ($urandom_range(9) == 0) ? 64'd0 : rand_bits(64);
				write_reg(REG_TOTAL_TOKENS, v);
				write_reg(REG_K1_GAIN, rand_bits(16));
				write_reg(REG_LENGTH_WEIGHT, 64'($urandom_range(0, 511)));
				for (int k = 0; k < 50; k++)
					offer_posting(random_posting(), 1'b0, '0, gap_pct[ph]);
			end
		end
		start <= 1'b0;
		typed_chk <= 1'b0;

		@(posedge clk);
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
